>>> hw/rtl/sha256_byte_stream_hasher_top_defines.svh
// Assertion macros used by the SHA-256 byte stream hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define SHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/shs_pkg.sv
// Types, constants and round functions of the SHA-256 byte stream hasher.
package shs_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } result_t;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef enum logic {
        OP_WORD   = 1'b0,
        OP_DIGEST = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] word;
    } q_entry_t;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> hw/rtl/sha256_byte_stream_hasher_top.sv
// Top level of the SHA-256 byte stream hasher.
//
//  channel  dir  handshake                  payload
//  item     in   item_valid / item_stall    item_t   {kind, data_byte}
//  digest   out  digest_valid / digest_stall result_t {digest_word, word_index, last}
//
// Bytes are taken one per cycle while the word queue has room, packed four to a queue word.
// The engine runs one round per cycle: 64 rounds plus one add per block; its 16 loads wait
// on input bytes once the four queued words are used.
// A finish stalls the input while its padding, length and marker words are queued,
// then one compression (two when 56 or more bytes sit in the last block) and 8 digest words.
// Reset needs no clearing pass; a stalled digest output holds the engine and backs up the input.
module sha256_byte_stream_hasher_top
    import shs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    digest_valid,
    input  logic    digest_stall,
    output result_t digest
);

    logic     push;
    q_entry_t push_entry;
    logic     q_full;
    logic     pop;
    q_entry_t head;
    logic     head_valid;

    shs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    shs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    shs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (digest_valid),
        .out_stall  (digest_stall),
        .out_data   (digest)
    );

endmodule

>>> hw/rtl/shs_fifo.sv
// Short word queue between the byte packer and the compression engine.
module shs_fifo
    import shs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output q_entry_t head,
    output logic     head_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (fill_reg == CW'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hw/rtl/shs_front.sv
// Input side: counts and packs message bytes into words and generates the padding.
module shs_front
    import shs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  item_t    item,
    output logic     push,
    output q_entry_t push_entry,
    input  logic     q_full
);

    typedef enum logic [3:0] {
        FS_DATA = 4'b0001,
        FS_PAD  = 4'b0010,
        FS_LEN  = 4'b0100,
        FS_END  = 4'b1000
    } fstate_t;

    fstate_t      state_reg, state_next;
    logic [63:0]  count_reg, count_next;
    logic [23:0]  pack_reg, pack_next;
    logic [63:0]  len_reg, len_next;
    logic [3:0]   wcnt_reg, wcnt_next;
    logic         accept;
    logic [31:0]  pad_word;

    assign item_stall = (state_reg != FS_DATA) || q_full;
    assign accept     = item_valid && !item_stall;

    // Close the partial word with the 0x80 marker byte.
    always_comb
    begin
        case (count_reg[1:0])
            2'd0:    pad_word = 32'h8000_0000;
            2'd1:    pad_word = {pack_reg[7:0], 24'h80_0000};
            2'd2:    pad_word = {pack_reg[15:0], 16'h8000};
            default: pad_word = {pack_reg, 8'h80};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pack_next  = pack_reg;
        len_next   = len_reg;
        wcnt_next  = wcnt_reg;
        push       = 1'b0;
        push_entry = '{op: OP_WORD, word: 32'h0};
        case (state_reg)
            FS_DATA:
            begin
                if (accept)
                begin
                    if (item.kind == KIND_DATA)
                    begin
                        pack_next  = {pack_reg[15:0], item.data_byte};
                        count_next = count_reg + 64'd1;
                        if (count_reg[1:0] == 2'd3)
                        begin
                            push            = 1'b1;
                            push_entry.word = {pack_reg, item.data_byte};
                        end
                    end
                    else
                    begin
                        len_next        = {count_reg[60:0], 3'b000};
                        push            = 1'b1;
                        push_entry.word = pad_word;
                        wcnt_next       = count_reg[5:2] + 4'd1;
                        state_next      = FS_PAD;
                    end
                end
            end
            FS_PAD:
            begin
                if (!q_full)
                begin
                    push      = 1'b1;
                    wcnt_next = wcnt_reg + 4'd1;
                    if (wcnt_reg == 4'd14)
                    begin
                        push_entry.word = len_reg[63:32];
                        state_next      = FS_LEN;
                    end
                end
            end
            FS_LEN:
            begin
                if (!q_full)
                begin
                    push            = 1'b1;
                    push_entry.word = len_reg[31:0];
                    state_next      = FS_END;
                end
            end
            FS_END:
            begin
                if (!q_full)
                begin
                    push          = 1'b1;
                    push_entry.op = OP_DIGEST;
                    count_next    = 64'd0;
                    state_next    = FS_DATA;
                end
            end
            default:
            begin
                state_next = FS_DATA;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_DATA;
            count_reg <= 64'd0;
            wcnt_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            wcnt_reg  <= wcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pack_reg <= pack_next;
        len_reg  <= len_next;
    end

endmodule

>>> hw/rtl/shs_back.sv
// Compression engine: message schedule window, one round per cycle, digest output.
`include "sha256_byte_stream_hasher_top_defines.svh"

module shs_back
    import shs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  q_entry_t head,
    input  logic     head_valid,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_stall,
    output result_t  out_data
);

    typedef enum logic [3:0] {
        BS_LOAD = 4'b0001,
        BS_RUN  = 4'b0010,
        BS_ADD  = 4'b0100,
        BS_EMIT = 4'b1000
    } bstate_t;

    bstate_t      state_reg, state_next;
    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];
    logic [31:0]  hash_reg [8];
    logic [31:0]  hash_next [8];
    logic [3:0]   ld_cnt_reg, ld_cnt_next;
    logic [5:0]   round_reg, round_next;
    logic [2:0]   idx_reg, idx_next;
    logic         out_valid_reg, out_valid_next;
    result_t      out_reg, out_next;
    logic         load_out;
    logic [31:0]  ch;
    logic [31:0]  maj;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  w_new;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pop       = (state_reg == BS_LOAD) && head_valid;
    assign load_out  = !out_valid_reg || !out_stall;

    always_comb
    begin
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch + K[round_reg] + w_reg[0];
        t2    = big_sigma0(v_reg[0]) + maj;
        w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    end

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        v_next         = v_reg;
        hash_next      = hash_reg;
        ld_cnt_next    = ld_cnt_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            BS_LOAD:
            begin
                if (head_valid)
                begin
                    if (head.op == OP_WORD)
                    begin
                        for (int i = 0; i < 15; i++)
                        begin
                            w_next[i] = w_reg[i + 1];
                        end
                        w_next[15]  = head.word;
                        ld_cnt_next = ld_cnt_reg + 4'd1;
                        if (ld_cnt_reg == 4'd15)
                        begin
                            v_next     = hash_reg;
                            round_next = 6'd0;
                            state_next = BS_RUN;
                        end
                    end
                    else
                    begin
                        idx_next   = 3'd0;
                        state_next = BS_EMIT;
                    end
                end
            end
            BS_RUN:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = w_new;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = BS_ADD;
                end
            end
            BS_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
                state_next = BS_LOAD;
            end
            BS_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next       = 1'b1;
                    out_next.digest_word = hash_reg[0];
                    out_next.word_index  = idx_reg;
                    out_next.last        = (idx_reg == 3'd7);
                    // Rotate the digest out and refill with the initial values.
                    for (int i = 0; i < 7; i++)
                    begin
                        hash_next[i] = hash_reg[i + 1];
                    end
                    hash_next[7] = IV[idx_reg];
                    idx_next     = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = BS_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = BS_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_LOAD;
            hash_reg      <= IV;
            ld_cnt_reg    <= 4'd0;
            round_reg     <= 6'd0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            ld_cnt_reg    <= ld_cnt_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        v_reg   <= v_next;
        out_reg <= out_next;
    end

    `SHS_ASSERT_NEXT(a_run_ends_in_add, clk, rst_n, state_reg == BS_RUN && round_reg == 6'd63, state_reg == BS_ADD, "compression did not end after the last round")
    `SHS_ASSERT_NOW(a_digest_on_boundary, clk, rst_n, pop && head.op == OP_DIGEST, ld_cnt_reg == 4'd0, "digest request inside a partial block")
    `SHS_ASSERT_NEXT(a_iv_restored, clk, rst_n, state_reg == BS_EMIT && load_out && idx_reg == 3'd7, state_reg == BS_LOAD && hash_reg[0] == IV[0] && hash_reg[7] == IV[7], "hash not restored after digest")

endmodule
